>>> hdl/zals_pkg.sv
// Shared types and constants for the ZIP archive length scanner.
`default_nettype none

package zals_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    localparam int OUT_LEN_W           = 32;

    localparam logic [7:0] SIG_BYTE0      = 8'h50;
    localparam logic [7:0] SIG_BYTE1      = 8'h4b;
    localparam logic [7:0] LOCAL_TYPE0    = 8'h03;
    localparam logic [7:0] LOCAL_TYPE1    = 8'h04;
    localparam logic [7:0] CENTRAL_TYPE0  = 8'h01;
    localparam logic [7:0] CENTRAL_TYPE1  = 8'h02;
    localparam logic [7:0] EOCD_TYPE0     = 8'h05;
    localparam logic [7:0] EOCD_TYPE1     = 8'h06;

    typedef enum logic [2:0] {
        PH_MAGIC0 = 3'd0,
        PH_MAGIC1 = 3'd1,
        PH_TYPE0  = 3'd2,
        PH_TYPE1  = 3'd3,
        PH_HEADER = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_LOCAL   = 2'd1,
        KIND_CENTRAL = 2'd2,
        KIND_EOCD    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic [OUT_LEN_W-1:0]  length;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/zals_in_stage.sv
// Input register for archive bytes, released when the parser takes the word.
`default_nettype none

module zals_in_stage (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   data_byte,
    input  wire logic         archive_start,
    input  wire logic         archive_end,
    input  wire logic         consume,
    output logic              item_valid,
    output zals_pkg::item_t   item
);

    logic            valid_reg;
    logic            valid_next;
    zals_pkg::item_t item_reg;
    logic            take;

    // The held word blocks only while the parser cannot retire it.
    assign in_stall   = valid_reg && !consume;
    assign take       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data  <= data_byte;
            item_reg.start <= archive_start;
            item_reg.last  <= archive_end;
        end
    end

endmodule

`default_nettype wire

>>> hdl/zals_parser.sv
// Record walker: holds the scan state and evaluates one byte per cycle unless a result is blocked.
`default_nettype none

module zals_parser #(
    parameter int LENGTH_BITS = zals_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire zals_pkg::item_t  item,
    input  wire logic             out_free,
    output logic                  consume,
    output logic                  res_push,
    output zals_pkg::result_t     res
);

    localparam int LEN_EXT_W = (LENGTH_BITS + 1 > zals_pkg::OUT_LEN_W) ?
                               LENGTH_BITS + 1 : zals_pkg::OUT_LEN_W;

    localparam logic [5:0] LOCAL_HDR_LEN   = 6'd26;
    localparam logic [5:0] CENTRAL_HDR_LEN = 6'd42;
    localparam logic [5:0] EOCD_HDR_LEN    = 6'd18;

    // Byte offsets of the captured fields within each header.
    localparam logic [5:0] LFH_SIZE_AT    = 6'd18;
    localparam logic [5:0] LFH_NAME_AT    = 6'd22;
    localparam logic [5:0] LFH_EXTRA_AT   = 6'd24;
    localparam logic [5:0] CEN_NAME_AT    = 6'd24;
    localparam logic [5:0] CEN_EXTRA_AT   = 6'd26;
    localparam logic [5:0] CEN_COMMENT_AT = 6'd28;
    localparam logic [5:0] EOCD_COMMENT_AT = 6'd16;

    zals_pkg::phase_t         phase_reg, phase_cur, phase_next;
    zals_pkg::kind_t          kind_reg, kind_cur, kind_next;
    logic [5:0]               idx_reg, idx_cur, idx_next;
    logic [32:0]              skip_reg, skip_cur, skip_next;
    logic [7:0]               held_reg, held_cur, held_next;
    logic [15:0]              name_reg, name_cur, name_next;
    logic [15:0]              extra_reg, extra_cur, extra_next;
    logic [15:0]              comment_reg, comment_cur, comment_next;
    logic [31:0]              size_reg, size_cur, size_next;
    logic [LENGTH_BITS-1:0]   seen_reg, seen_cur, seen_next;
    logic                     finished_reg, finished_cur, finished_next;

    logic [15:0]              name_cap, extra_cap, comment_cap;
    logic [31:0]              size_cap;

    logic [LENGTH_BITS:0]     seen_inc;
    logic [LEN_EXT_W-1:0]     len_ext;
    logic                     live, ovf, go;
    logic                     magic_bad, type_bad;
    zals_pkg::kind_t          type_kind;
    logic [5:0]               idx_inc;
    logic [5:0]               hdr_len;
    logic                     hdr_last;
    logic [32:0]              skip_sum;
    logic                     skip_zero;
    logic [32:0]              skip_dec;
    logic                     skip_last;
    logic                     rec_close;
    logic                     rec_done;
    logic                     res_hit;
    zals_pkg::status_t        res_status;

    // A start mark clears the scan state before the byte is looked at.
    always_comb
    begin
        phase_cur    = phase_reg;
        kind_cur     = kind_reg;
        idx_cur      = idx_reg;
        skip_cur     = skip_reg;
        held_cur     = held_reg;
        name_cur     = name_reg;
        extra_cur    = extra_reg;
        comment_cur  = comment_reg;
        size_cur     = size_reg;
        seen_cur     = seen_reg;
        finished_cur = finished_reg;
        if (item.start)
        begin
            phase_cur    = zals_pkg::PH_MAGIC0;
            kind_cur     = zals_pkg::KIND_NONE;
            idx_cur      = '0;
            skip_cur     = '0;
            held_cur     = '0;
            name_cur     = '0;
            extra_cur    = '0;
            comment_cur  = '0;
            size_cur     = '0;
            seen_cur     = '0;
            finished_cur = 1'b0;
        end
    end

    // Little-endian field capture for the current header byte.
    always_comb
    begin
        name_cap    = name_cur;
        extra_cap   = extra_cur;
        comment_cap = comment_cur;
        size_cap    = size_cur;
        case (kind_cur)
            zals_pkg::KIND_LOCAL:
            begin
                if (idx_cur == LFH_SIZE_AT)              size_cap[7:0]    = item.data;
                if (idx_cur == LFH_SIZE_AT + 6'd1)       size_cap[15:8]   = item.data;
                if (idx_cur == LFH_SIZE_AT + 6'd2)       size_cap[23:16]  = item.data;
                if (idx_cur == LFH_SIZE_AT + 6'd3)       size_cap[31:24]  = item.data;
                if (idx_cur == LFH_NAME_AT)              name_cap[7:0]    = item.data;
                if (idx_cur == LFH_NAME_AT + 6'd1)       name_cap[15:8]   = item.data;
                if (idx_cur == LFH_EXTRA_AT)             extra_cap[7:0]   = item.data;
                if (idx_cur == LFH_EXTRA_AT + 6'd1)      extra_cap[15:8]  = item.data;
            end
            zals_pkg::KIND_CENTRAL:
            begin
                if (idx_cur == CEN_NAME_AT)              name_cap[7:0]    = item.data;
                if (idx_cur == CEN_NAME_AT + 6'd1)       name_cap[15:8]   = item.data;
                if (idx_cur == CEN_EXTRA_AT)             extra_cap[7:0]   = item.data;
                if (idx_cur == CEN_EXTRA_AT + 6'd1)      extra_cap[15:8]  = item.data;
                if (idx_cur == CEN_COMMENT_AT)           comment_cap[7:0] = item.data;
                if (idx_cur == CEN_COMMENT_AT + 6'd1)    comment_cap[15:8] = item.data;
            end
            default:
            begin
                if (idx_cur == EOCD_COMMENT_AT)          comment_cap[7:0] = item.data;
                if (idx_cur == EOCD_COMMENT_AT + 6'd1)   comment_cap[15:8] = item.data;
            end
        endcase
    end

    // Shared decode of the byte against the current phase.
    always_comb
    begin
        seen_inc  = {1'b0, seen_cur} + (LENGTH_BITS + 1)'(1);
        live      = !finished_cur;
        ovf       = seen_inc[LENGTH_BITS];
        go        = live && !ovf;

        magic_bad = ((phase_cur == zals_pkg::PH_MAGIC0) && (item.data != zals_pkg::SIG_BYTE0))
                 || ((phase_cur == zals_pkg::PH_MAGIC1) && (item.data != zals_pkg::SIG_BYTE1));

        if ((held_cur == zals_pkg::LOCAL_TYPE0) && (item.data == zals_pkg::LOCAL_TYPE1))
        begin
            type_kind = zals_pkg::KIND_LOCAL;
        end
        else if ((held_cur == zals_pkg::CENTRAL_TYPE0) && (item.data == zals_pkg::CENTRAL_TYPE1))
        begin
            type_kind = zals_pkg::KIND_CENTRAL;
        end
        else if ((held_cur == zals_pkg::EOCD_TYPE0) && (item.data == zals_pkg::EOCD_TYPE1))
        begin
            type_kind = zals_pkg::KIND_EOCD;
        end
        else
        begin
            type_kind = zals_pkg::KIND_NONE;
        end
        type_bad = (phase_cur == zals_pkg::PH_TYPE1) && (type_kind == zals_pkg::KIND_NONE);

        case (kind_cur)
            zals_pkg::KIND_LOCAL:   hdr_len = LOCAL_HDR_LEN;
            zals_pkg::KIND_CENTRAL: hdr_len = CENTRAL_HDR_LEN;
            default:                hdr_len = EOCD_HDR_LEN;
        endcase
        idx_inc  = idx_cur + 6'd1;
        hdr_last = (phase_cur == zals_pkg::PH_HEADER) && (idx_inc >= hdr_len);

        case (kind_cur)
            zals_pkg::KIND_LOCAL:
                skip_sum = {17'd0, name_cap} + {17'd0, extra_cap} + {1'b0, size_cap};
            zals_pkg::KIND_CENTRAL:
                skip_sum = {17'd0, name_cap} + {17'd0, extra_cap} + {17'd0, comment_cap};
            default:
                skip_sum = {17'd0, comment_cap};
        endcase
        skip_zero = (skip_sum == '0);

        skip_dec  = (skip_cur != '0) ? (skip_cur - 33'd1) : '0;
        skip_last = (phase_cur == zals_pkg::PH_SKIP) && (skip_dec == '0);

        rec_close = (hdr_last && skip_zero) || skip_last;
        rec_done  = rec_close && (kind_cur == zals_pkg::KIND_EOCD);
    end

    // Result outputs.
    always_comb
    begin
        res_hit    = 1'b0;
        res_status = zals_pkg::ST_DONE;
        if (live)
        begin
            if (ovf)
            begin
                res_hit    = 1'b1;
                res_status = zals_pkg::ST_OVERFLOW;
            end
            else if (magic_bad)
            begin
                res_hit    = 1'b1;
                res_status = zals_pkg::ST_BAD_MAGIC;
            end
            else if (type_bad)
            begin
                res_hit    = 1'b1;
                res_status = zals_pkg::ST_BAD_TYPE;
            end
            else if (rec_done)
            begin
                res_hit    = 1'b1;
                res_status = zals_pkg::ST_DONE;
            end
            else if (item.last)
            begin
                res_hit    = 1'b1;
                res_status = zals_pkg::ST_TRUNCATED;
            end
        end
    end

    // Every reported length is the count including this byte.
    assign len_ext    = LEN_EXT_W'(seen_inc);
    assign res.status = res_status;
    assign res.length = len_ext[zals_pkg::OUT_LEN_W-1:0];

    assign consume  = item_valid && (!res_hit || out_free);
    assign res_push = consume && res_hit;

    // Next state. Phase updates after an error are harmless since the scan
    // is then finished until the next start mark.
    always_comb
    begin
        phase_next    = phase_cur;
        kind_next     = kind_cur;
        idx_next      = idx_cur;
        skip_next     = skip_cur;
        held_next     = held_cur;
        name_next     = name_cur;
        extra_next    = extra_cur;
        comment_next  = comment_cur;
        size_next     = size_cur;
        seen_next     = seen_cur;
        finished_next = finished_cur || res_hit;
        if (go)
        begin
            seen_next = seen_inc[LENGTH_BITS-1:0];
            case (phase_cur)
                zals_pkg::PH_MAGIC0:
                begin
                    phase_next = zals_pkg::PH_MAGIC1;
                end
                zals_pkg::PH_MAGIC1:
                begin
                    phase_next = zals_pkg::PH_TYPE0;
                end
                zals_pkg::PH_TYPE0:
                begin
                    held_next  = item.data;
                    phase_next = zals_pkg::PH_TYPE1;
                end
                zals_pkg::PH_TYPE1:
                begin
                    kind_next    = type_kind;
                    name_next    = '0;
                    extra_next   = '0;
                    comment_next = '0;
                    size_next    = '0;
                    idx_next     = '0;
                    phase_next   = zals_pkg::PH_HEADER;
                end
                zals_pkg::PH_HEADER:
                begin
                    name_next    = name_cap;
                    extra_next   = extra_cap;
                    comment_next = comment_cap;
                    size_next    = size_cap;
                    idx_next     = idx_inc;
                    if (hdr_last)
                    begin
                        idx_next = '0;
                        if (skip_zero)
                        begin
                            phase_next = zals_pkg::PH_MAGIC0;
                        end
                        else
                        begin
                            skip_next  = skip_sum;
                            phase_next = zals_pkg::PH_SKIP;
                        end
                    end
                end
                zals_pkg::PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_last)
                    begin
                        phase_next = zals_pkg::PH_MAGIC0;
                    end
                end
                default:
                begin
                    phase_next = zals_pkg::PH_MAGIC0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= zals_pkg::PH_MAGIC0;
            kind_reg     <= zals_pkg::KIND_NONE;
            idx_reg      <= '0;
            skip_reg     <= '0;
            held_reg     <= '0;
            name_reg     <= '0;
            extra_reg    <= '0;
            comment_reg  <= '0;
            size_reg     <= '0;
            seen_reg     <= '0;
            finished_reg <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            idx_reg      <= idx_next;
            skip_reg     <= skip_next;
            held_reg     <= held_next;
            name_reg     <= name_next;
            extra_reg    <= extra_next;
            comment_reg  <= comment_next;
            size_reg     <= size_next;
            seen_reg     <= seen_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/zals_out_stage.sv
// Result register that holds a scan result until the sink takes the word.
`default_nettype none

module zals_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_push,
    input  wire zals_pkg::result_t  res,
    output logic                    out_free,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              scan_status,
    output logic [zals_pkg::OUT_LEN_W-1:0] archive_length
);

    logic              valid_reg;
    logic              valid_next;
    zals_pkg::result_t res_reg;

    assign out_free       = !valid_reg || !out_stall;
    assign out_valid      = valid_reg;
    assign scan_status    = res_reg.status;
    assign archive_length = res_reg.length;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (res_push)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> hdl/zip_archive_length_scanner.sv
// Top level of the ZIP archive length scanner.
//
//  channel  direction  handshake            word
//  in       sink       in_valid / in_stall  data_byte, archive_start, archive_end
//  out      source     out_valid/ out_stall scan_status, archive_length
//
// One archive byte is taken every cycle while in_stall is low; a byte waits in the
// input register, and its result, if any, enters the result register when consumed.
// The single parse pass between the input and result registers sets this rate.
// Reset clears all scan state; archive_start clears it again for a new archive.
// Input stalls only when a byte would produce a result while the held result
// is still stalled; bytes that produce no result keep flowing.
`default_nettype none

module zip_archive_length_scanner #(
    parameter int LENGTH_BITS = zals_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        archive_start,
    input  wire logic        archive_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       scan_status,
    output logic [zals_pkg::OUT_LEN_W-1:0] archive_length
);

    logic              item_valid;
    zals_pkg::item_t   item;
    logic              consume;
    logic              res_push;
    zals_pkg::result_t res;
    logic              out_free;

    zals_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .archive_start (archive_start),
        .archive_end   (archive_end),
        .consume       (consume),
        .item_valid    (item_valid),
        .item          (item)
    );

    zals_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .consume    (consume),
        .res_push   (res_push),
        .res        (res)
    );

    zals_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_push       (res_push),
        .res            (res),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scan_status    (scan_status),
        .archive_length (archive_length)
    );

endmodule

`default_nettype wire

>>> hdl/zals_checker.sv
// Port-level checks for the ZIP archive length scanner, bound to the top level.
`default_nettype none

module zals_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  scan_status,
    input  wire logic [zals_pkg::OUT_LEN_W-1:0] archive_length
);

    // A result word is one of the defined status codes.
    a_status_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (scan_status <= zals_pkg::ST_OVERFLOW)
    ) else $error("scan_status out of range");

    // A stalled result word holds.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(scan_status) && $stable(archive_length))
    ) else $error("stalled result changed");

    // Input backpressure comes only from a result word held by the sink.
    a_stall_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input stalled without a held result");

endmodule

bind zip_archive_length_scanner zals_checker u_zals_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scan_status    (scan_status),
    .archive_length (archive_length)
);

`default_nettype wire

>>> verif/tb_zip_archive_length_scanner.sv
// Self-checking testbench for the ZIP archive length scanner, with a built-in predictor.
module tb_zip_archive_length_scanner;

    localparam int LEN_BITS = zals_pkg::LENGTH_BITS_DEFAULT;
    localparam logic [32:0] LEN_LIMIT = (33'd1 << LEN_BITS) - 33'd1;
    localparam int LOCAL_HDR_LEN = 26;
    localparam int CENTRAL_HDR_LEN = 42;
    localparam int EOCD_HDR_LEN = 18;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [7:0]        data;
        logic              first;
        logic              last;
        logic              typed;
        logic              has_result;
        zals_pkg::status_t status;
        logic [31:0]       length;
    } step_row_t;

    localparam int ROW_COUNT = 25;
    localparam step_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{8'h00,                   1'b1, 1'b0, 1'b1, 1'b1, zals_pkg::ST_BAD_MAGIC, 32'd1},
        '{zals_pkg::SIG_BYTE0,     1'b0, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::SIG_BYTE0,     1'b1, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{8'hFF,                   1'b0, 1'b0, 1'b1, 1'b1, zals_pkg::ST_BAD_MAGIC, 32'd2},
        '{zals_pkg::SIG_BYTE0,     1'b1, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::SIG_BYTE1,     1'b0, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::LOCAL_TYPE0,   1'b0, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::CENTRAL_TYPE1, 1'b0, 1'b0, 1'b1, 1'b1, zals_pkg::ST_BAD_TYPE,  32'd4},
        '{zals_pkg::SIG_BYTE0,     1'b1, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::SIG_BYTE1,     1'b0, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::EOCD_TYPE0,    1'b0, 1'b0, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::EOCD_TYPE1,    1'b0, 1'b1, 1'b1, 1'b1, zals_pkg::ST_TRUNCATED, 32'd4},
        '{8'hFF,                   1'b1, 1'b1, 1'b1, 1'b1, zals_pkg::ST_BAD_MAGIC, 32'd1},
        '{zals_pkg::SIG_BYTE0,     1'b1, 1'b1, 1'b1, 1'b1, zals_pkg::ST_TRUNCATED, 32'd1},
        '{8'h00,                   1'b0, 1'b1, 1'b1, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::SIG_BYTE0,     1'b1, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::SIG_BYTE1,     1'b0, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::CENTRAL_TYPE0, 1'b0, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::CENTRAL_TYPE1, 1'b0, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{8'h5A,                   1'b0, 1'b1, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::SIG_BYTE0,     1'b1, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::SIG_BYTE1,     1'b0, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::LOCAL_TYPE0,   1'b0, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{zals_pkg::LOCAL_TYPE1,   1'b0, 1'b0, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0},
        '{8'hA5,                   1'b0, 1'b1, 1'b0, 1'b0, zals_pkg::ST_DONE,      32'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        archive_start;
    logic        archive_end;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  scan_status;
    logic [31:0] archive_length;

    // Typed expectation that travels with a directed word.
    logic              row_typed;
    logic              row_has;
    zals_pkg::result_t row_want;

    zals_pkg::result_t pending_results[$];
    logic [7:0]        arc_bytes[$];
    bit                open_ended;
    bit                calm;
    bit                hold_request;
    int                mismatch_count;
    int                parsed_count;
    int                cycle_count;

    // Predicted scanner state.
    zals_pkg::phase_t  phase_now;
    zals_pkg::kind_t   kind_now;
    logic [5:0]        hdr_pos;
    logic [32:0]       skip_count;
    logic [7:0]        type_first;
    logic [15:0]       len_name;
    logic [15:0]       len_extra;
    logic [15:0]       len_comment;
    logic [31:0]       data_len;
    logic [32:0]       byte_count;
    bit                scan_over;

    zip_archive_length_scanner #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .archive_start(archive_start),
        .archive_end(archive_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .scan_status(scan_status),
        .archive_length(archive_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_scan();
        phase_now = zals_pkg::PH_MAGIC0;
        kind_now = zals_pkg::KIND_NONE;
        hdr_pos = '0;
        skip_count = '0;
        type_first = '0;
        len_name = '0;
        len_extra = '0;
        len_comment = '0;
        data_len = '0;
        byte_count = '0;
        scan_over = 1'b0;
    endfunction

    function automatic bit finish_scan(input zals_pkg::status_t code,
                                       input logic [32:0] count,
                                       output zals_pkg::result_t res);
        res.status = code;
        res.length = count[31:0];
        scan_over = 1'b1;
        return 1'b1;
    endfunction

    // Only the end record reports at its close; other records go back to the signature.
    function automatic bit end_of_record(output zals_pkg::result_t res);
        res = '0;
        if (kind_now == zals_pkg::KIND_EOCD)
        begin
            return finish_scan(zals_pkg::ST_DONE, byte_count, res);
        end
        phase_now = zals_pkg::PH_MAGIC0;
        return 1'b0;
    endfunction

    function automatic bit scan_byte(input logic [7:0] b, input logic first, input logic last,
                                     output zals_pkg::result_t res);
        logic [32:0] total;
        bit          hit;
        int          hdr_len;
        hit = 1'b0;
        res = '0;
        if (first)
        begin
            clear_scan();
        end
        if (scan_over)
        begin
            return 1'b0;
        end
        // A word past the counter limit is not parsed at all.
        if (byte_count + 33'd1 > LEN_LIMIT)
        begin
            return finish_scan(zals_pkg::ST_OVERFLOW, byte_count + 33'd1, res);
        end
        byte_count = byte_count + 33'd1;
        case (phase_now)
            zals_pkg::PH_MAGIC0:
            begin
                if (b != zals_pkg::SIG_BYTE0)
                begin
                    hit = finish_scan(zals_pkg::ST_BAD_MAGIC, byte_count, res);
                end
                else
                begin
                    phase_now = zals_pkg::PH_MAGIC1;
                end
            end
            zals_pkg::PH_MAGIC1:
            begin
                if (b != zals_pkg::SIG_BYTE1)
                begin
                    hit = finish_scan(zals_pkg::ST_BAD_MAGIC, byte_count, res);
                end
                else
                begin
                    phase_now = zals_pkg::PH_TYPE0;
                end
            end
            zals_pkg::PH_TYPE0:
            begin
                type_first = b;
                phase_now = zals_pkg::PH_TYPE1;
            end
            zals_pkg::PH_TYPE1:
            begin
                if (type_first == zals_pkg::LOCAL_TYPE0 && b == zals_pkg::LOCAL_TYPE1)
                begin
                    kind_now = zals_pkg::KIND_LOCAL;
                end
                else if (type_first == zals_pkg::CENTRAL_TYPE0 &&
                         b == zals_pkg::CENTRAL_TYPE1)
                begin
                    kind_now = zals_pkg::KIND_CENTRAL;
                end
                else if (type_first == zals_pkg::EOCD_TYPE0 && b == zals_pkg::EOCD_TYPE1)
                begin
                    kind_now = zals_pkg::KIND_EOCD;
                end
                else
                begin
                    hit = finish_scan(zals_pkg::ST_BAD_TYPE, byte_count, res);
                end
                if (!hit)
                begin
                    len_name = '0;
                    len_extra = '0;
                    len_comment = '0;
                    data_len = '0;
                    hdr_pos = '0;
                    phase_now = zals_pkg::PH_HEADER;
                end
            end
            zals_pkg::PH_HEADER:
            begin
                // Length fields are little-endian at fixed offsets in each header.
                case (kind_now)
                    zals_pkg::KIND_LOCAL:
                    begin
                        case (hdr_pos)
                            6'd18: data_len[7:0] = b;
                            6'd19: data_len[15:8] = b;
                            6'd20: data_len[23:16] = b;
                            6'd21: data_len[31:24] = b;
                            6'd22: len_name[7:0] = b;
                            6'd23: len_name[15:8] = b;
                            6'd24: len_extra[7:0] = b;
                            6'd25: len_extra[15:8] = b;
                            default: ;
                        endcase
                    end
                    zals_pkg::KIND_CENTRAL:
                    begin
                        case (hdr_pos)
                            6'd24: len_name[7:0] = b;
                            6'd25: len_name[15:8] = b;
                            6'd26: len_extra[7:0] = b;
                            6'd27: len_extra[15:8] = b;
                            6'd28: len_comment[7:0] = b;
                            6'd29: len_comment[15:8] = b;
                            default: ;
                        endcase
                    end
                    default:
                    begin
                        case (hdr_pos)
                            6'd16: len_comment[7:0] = b;
                            6'd17: len_comment[15:8] = b;
                            default: ;
                        endcase
                    end
                endcase
                hdr_pos = hdr_pos + 6'd1;
                hdr_len = (kind_now == zals_pkg::KIND_LOCAL) ? LOCAL_HDR_LEN :
                          (kind_now == zals_pkg::KIND_CENTRAL) ? CENTRAL_HDR_LEN :
                          EOCD_HDR_LEN;
                if (hdr_pos == hdr_len)
                begin
                    if (kind_now == zals_pkg::KIND_LOCAL)
                    begin
                        total = 33'(len_name) + 33'(len_extra) + 33'(data_len);
                    end
                    else if (kind_now == zals_pkg::KIND_CENTRAL)
                    begin
                        total = 33'(len_name) + 33'(len_extra) + 33'(len_comment);
                    end
                    else
                    begin
                        total = 33'(len_comment);
                    end
                    hdr_pos = '0;
                    if (total == '0)
                    begin
                        hit = end_of_record(res);
                    end
                    else
                    begin
                        skip_count = total;
                        phase_now = zals_pkg::PH_SKIP;
                    end
                end
            end
            default:
            begin
                if (skip_count != '0)
                begin
                    skip_count = skip_count - 33'd1;
                end
                if (skip_count == '0)
                begin
                    hit = end_of_record(res);
                end
            end
        endcase
        if (!hit && last)
        begin
            hit = finish_scan(zals_pkg::ST_TRUNCATED, byte_count, res);
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int gap_len();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic step_row_t plain_row(input logic [7:0] b, input logic first,
                                            input logic last);
        step_row_t r;
        r = '0;
        r.data = b;
        r.first = first;
        r.last = last;
        return r;
    endfunction

    task automatic send_row(input step_row_t r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= r.data;
        archive_start <= r.first;
        archive_end <= r.last;
        row_typed <= r.typed;
        row_has <= r.has_result;
        row_want <= '{status: r.status, length: r.length};
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic put_header(input logic [7:0] t0, input logic [7:0] t1, input int hdr_len);
        arc_bytes.push_back(zals_pkg::SIG_BYTE0);
        arc_bytes.push_back(zals_pkg::SIG_BYTE1);
        arc_bytes.push_back(t0);
        arc_bytes.push_back(t1);
        repeat (hdr_len) arc_bytes.push_back(8'($urandom));
    endtask

    task automatic put_field(input int pos, input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
        begin
            arc_bytes[pos + i] = v[8*i +: 8];
        end
    endtask

    task automatic put_skip(input int n);
        repeat (n) arc_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [15:0] pick_len();
        if ($urandom_range(0, 99) < 35)
        begin
            return 16'd0;
        end
        return 16'($urandom_range(1, 5));
    endfunction

    // Builds a well-formed archive; a rare huge length leaves it open-ended.
    task automatic build_archive();
        int          base;
        logic [15:0] nl;
        logic [15:0] xl;
        logic [15:0] cl;
        logic [31:0] ds;
        arc_bytes.delete();
        open_ended = 1'b0;
        repeat ($urandom_range(0, 2))
        begin
            put_header(zals_pkg::LOCAL_TYPE0, zals_pkg::LOCAL_TYPE1, LOCAL_HDR_LEN);
            base = arc_bytes.size() - LOCAL_HDR_LEN;
            nl = pick_len();
            xl = pick_len();
            ds = 32'(pick_len());
            if ($urandom_range(0, 19) == 0)
            begin
                ds = $urandom;
                open_ended = 1'b1;
            end
            put_field(base + 18, ds, 4);
            put_field(base + 22, 32'(nl), 2);
            put_field(base + 24, 32'(xl), 2);
            if (open_ended)
            begin
                put_skip($urandom_range(0, 12));
                return;
            end
            put_skip(nl + xl + ds);
        end
        repeat ($urandom_range(0, 2))
        begin
            put_header(zals_pkg::CENTRAL_TYPE0, zals_pkg::CENTRAL_TYPE1, CENTRAL_HDR_LEN);
            base = arc_bytes.size() - CENTRAL_HDR_LEN;
            nl = pick_len();
            xl = pick_len();
            cl = pick_len();
            if ($urandom_range(0, 19) == 0)
            begin
                nl = 16'($urandom_range(0, 65535));
                open_ended = 1'b1;
            end
            put_field(base + 24, 32'(nl), 2);
            put_field(base + 26, 32'(xl), 2);
            put_field(base + 28, 32'(cl), 2);
            if (open_ended)
            begin
                put_skip($urandom_range(0, 12));
                return;
            end
            put_skip(nl + xl + cl);
        end
        put_header(zals_pkg::EOCD_TYPE0, zals_pkg::EOCD_TYPE1, EOCD_HDR_LEN);
        base = arc_bytes.size() - EOCD_HDR_LEN;
        cl = pick_len();
        put_field(base + 16, 32'(cl), 2);
        put_skip(cl);
    endtask

    task automatic send_archive();
        int mode;
        int cut;
        int pos;
        bit tail_end;
        mode = $urandom_range(0, 99);
        cut = arc_bytes.size();
        tail_end = $urandom_range(0, 1);
        if (open_ended)
        begin
            tail_end = ($urandom_range(0, 4) != 0);
        end
        else if (mode >= 93)
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_row(plain_row(8'($urandom), $urandom_range(0, 3) == 0,
                                   $urandom_range(0, 3) == 0));
            end
            return;
        end
        else if (mode >= 86)
        begin
            // Abandoned part way; the next archive start clears it.
            cut = $urandom_range(1, arc_bytes.size());
            tail_end = 1'b0;
        end
        else if (mode >= 78)
        begin
            pos = $urandom_range(0, arc_bytes.size() - 1);
            arc_bytes[pos] = arc_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        else if (mode >= 66)
        begin
            cut = $urandom_range(1, arc_bytes.size());
            tail_end = 1'b1;
        end
        for (int i = 0; i < cut; i++)
        begin
            send_row(plain_row(arc_bytes[i], i == 0, tail_end && i == cut - 1));
        end
        // Words after a finished scan are dropped without a result.
        if (!open_ended && mode < 66)
        begin
            repeat ($urandom_range(0, 2))
            begin
                send_row(plain_row(8'($urandom), 1'b0, $urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        zals_pkg::result_t predicted;
        zals_pkg::result_t want;
        bit                hit;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result status %0d length %0d",
                                              scan_status, archive_length));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (scan_status !== want.status)
                    begin
                        report_mismatch($sformatf("scan_status got %0d want %0d",
                                                  scan_status, want.status));
                    end
                    if (archive_length !== want.length)
                    begin
                        report_mismatch($sformatf("archive_length got %0d want %0d",
                                                  archive_length, want.length));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (archive_start || !scan_over)
                begin
                    parsed_count++;
                end
                hit = scan_byte(data_byte, archive_start, archive_end, predicted);
                if (row_typed)
                begin
                    if (row_has)
                    begin
                        pending_results.push_back(row_want);
                    end
                end
                else if (hit)
                begin
                    pending_results.push_back(predicted);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold on request.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = gap_len();
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int          random_start;
        logic [7:0]  junk;
        clear_scan();
        mismatch_count = 0;
        parsed_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= '0;
        archive_start <= 1'b0;
        archive_end <= 1'b0;
        row_typed <= 1'b0;
        row_has <= 1'b0;
        row_want <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROW_COUNT; i++)
        begin
            send_row(DIRECTED_ROWS[i]);
        end

        // Each single bad word ends a scan, so a held output soon backs up the input.
        hold_request = 1'b1;
        repeat (16)
        begin
            junk = 8'($urandom);
            if (junk == zals_pkg::SIG_BYTE0)
            begin
                junk = 8'h00;
            end
            send_row(plain_row(junk, 1'b1, 1'b0));
        end

        random_start = parsed_count;
        while (parsed_count - random_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                calm = !calm;
            end
            build_archive();
            send_archive();
        end
        calm = 1'b0;
        wait_for_drain();

        // A few more archives once the block has run dry.
        repeat (2)
        begin
            build_archive();
            send_archive();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
